// File: rtl/cbc_pkg.sv
`timescale 1ns / 1ps

package cbc_pkg;

   localparam int COORD_W = 12;
   localparam int DIAM_W  = 13;

   typedef struct packed {
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
      logic [DIAM_W-1:0]  diameter;
   } rsp_type;

endpackage

// File: rtl/cbc_track.sv
`timescale 1ns / 1ps

module cbc_track #(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  cbc_pkg::req_type      point,
   output logic                  start,
   output logic [COORD_BITS-1:0] min_x,
   output logic [COORD_BITS-1:0] max_x,
   output logic [COORD_BITS-1:0] min_y,
   output logic [COORD_BITS-1:0] max_y
);

   localparam logic [1:0] COUNT_MAX = 2'd3;

   logic [1:0]            count_ff, count_in;
   logic [COORD_BITS-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [COORD_BITS-1:0] px, py;
   logic                  first;

   assign px    = COORD_BITS'(point.point_x);
   assign py    = COORD_BITS'(point.point_y);
   assign first = (count_ff == 2'd0);

   // box including the current point, also handed to the root unit
   always_comb begin
      min_x = (first || px < min_x_ff) ? px : min_x_ff;
      max_x = (first || px > max_x_ff) ? px : max_x_ff;
      min_y = (first || py < min_y_ff) ? py : min_y_ff;
      max_y = (first || py > max_y_ff) ? py : max_y_ff;
   end

   // a last point with an earlier point in the contour ends a real box
   assign start = accept && point.last_point && !first;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (point.last_point) begin
            count_in = 2'd0;
         end else if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         min_x_ff <= min_x;
         max_x_ff <= max_x;
         min_y_ff <= min_y;
         max_y_ff <= max_y;
      end
   end

endmodule

// File: rtl/cbc_root.sv
`timescale 1ns / 1ps

module cbc_root #(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] min_x,
   input  logic [COORD_BITS-1:0] max_x,
   input  logic [COORD_BITS-1:0] min_y,
   input  logic [COORD_BITS-1:0] max_y,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cbc_pkg::rsp_type      rsp_data
);

   localparam int ROOT_W = COORD_BITS + 1;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int CNT_W  = $clog2(ROOT_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_W - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQX  = 3'd1;
   localparam logic [2:0] ST_SQY  = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_HOLD = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [COORD_BITS-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [RAD_W-1:0]      acc_ff, acc_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [CNT_W-1:0]      step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cbc_pkg::rsp_type      rsp_data_ff;

   logic [COORD_BITS-1:0]   sub_hi, sub_lo, diff;
   logic [2*COORD_BITS-1:0] square;
   logic [REM_W-1:0]        rem_sh, trial;
   logic                    fits;
   logic [COORD_BITS:0]     sum_x, sum_y;
   logic                    out_free;

   // one subtract and multiply shared by the x and y square
   assign sub_hi = (state_ff == ST_SQX) ? max_x_ff : max_y_ff;
   assign sub_lo = (state_ff == ST_SQX) ? min_x_ff : min_y_ff;
   assign diff   = sub_hi - sub_lo;
   assign square = diff * diff;

   // restoring root step, two radicand bits per cycle
   assign rem_sh = {rem_ff[ROOT_W-1:0], acc_ff[RAD_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign fits   = (rem_sh >= trial);

   assign sum_x    = {1'b0, min_x_ff} + {1'b0, max_x_ff};
   assign sum_y    = {1'b0, min_y_ff} + {1'b0, max_y_ff};
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = LAST_STEP;
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            acc_in   = RAD_W'(square);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            acc_in   = acc_ff + RAD_W'(square);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rem_in  = fits ? (rem_sh - trial) : rem_sh;
            root_in = {root_ff[ROOT_W-2:0], fits};
            acc_in  = acc_ff << 2;
            step_in = step_ff - CNT_W'(1);
            if (step_ff == '0) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      if (state_ff == ST_IDLE && start) begin
         min_x_ff <= min_x;
         max_x_ff <= max_x;
         min_y_ff <= min_y;
         max_y_ff <= max_y;
      end
      if (state_ff == ST_HOLD && out_free) begin
         rsp_data_ff.center_x <= cbc_pkg::COORD_W'(sum_x[COORD_BITS:1]);
         rsp_data_ff.center_y <= cbc_pkg::COORD_W'(sum_y[COORD_BITS:1]);
         rsp_data_ff.diameter <= cbc_pkg::DIAM_W'(root_ff);
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ST_IDLE)
      else $error("contour end arrived while root unit busy");

   a_root_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && step_ff == '0) |=> state_ff == ST_HOLD)
      else $error("root sequence did not finish after last step");

   a_hold_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished result not moved to output register");

   a_hold_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD && !out_free) |=> state_ff == ST_HOLD)
      else $error("result left hold while output register full");

endmodule

// File: rtl/contour_bounding_circle.sv
`timescale 1ns / 1ps

// Bounding circle estimate over traced contours. Each item is one point; the
// point flagged last_point closes the contour. Ordinary points are taken one
// per cycle while the root unit is idle and only update the running box. A
// last point of a contour with two or more points starts the shared
// square/root unit: one multiplier squares dx and then dy, a restoring square
// root resolves one result bit per cycle, and the result then moves to the
// output register. req_ready stays low from such an item until that move,
// longer if the previous result is still waiting to be taken. A single point
// contour gives no result item and no stall. The result carries the box
// center as halved sums and the floor root of the squared diagonal.
module contour_bounding_circle #(
   parameter int COORD_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cbc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cbc_pkg::rsp_type rsp_data
);

   logic                  accept;
   logic                  start;
   logic                  busy;
   logic [COORD_BITS-1:0] min_x, max_x, min_y, max_y;

   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;

   cbc_track #(
      .COORD_BITS(COORD_BITS)
   ) u_track (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .point (req_data),
      .start (start),
      .min_x (min_x),
      .max_x (max_x),
      .min_y (min_y),
      .max_y (max_y)
   );

   cbc_root #(
      .COORD_BITS(COORD_BITS)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .min_x    (min_x),
      .max_x    (max_x),
      .min_y    (min_y),
      .max_y    (max_y),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

// File: test/contour_bounding_circle_tb.sv
`timescale 1ns / 1ps

module contour_bounding_circle_tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 40;
   localparam int COORD_TOP     = (1 << cbc_pkg::COORD_W) - 1;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   cbc_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   cbc_pkg::rsp_type rsp_data;

   // box tracker mirroring the block
   logic [cbc_pkg::COORD_W-1:0] box_min_x = '0, box_min_y = '0;
   logic [cbc_pkg::COORD_W-1:0] box_max_x = '0, box_max_y = '0;
   logic [1:0]                  pts_in_contour = '0;
   cbc_pkg::rsp_type            circle_q[$];
   cbc_pkg::rsp_type            circle_want;

   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic holding = 1'b0;
   event hold_trigger;

   int cycles = 0;
   int errors = 0;
   int points_sent = 0;
   int contours_sent = 0;
   int circles_checked = 0;

   contour_bounding_circle #(.COORD_BITS(cbc_pkg::COORD_W)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [cbc_pkg::DIAM_W-1:0] floor_root(input int v);
      int root;
      root = 0;
      for (int b = cbc_pkg::DIAM_W - 1; b >= 0; b--) begin
         if ((root + (1 << b)) * (root + (1 << b)) <= v) root = root + (1 << b);
      end
      return root[cbc_pkg::DIAM_W-1:0];
   endfunction

   task automatic track_point(input cbc_pkg::req_type pt);
      int               sum_x, sum_y, dx, dy;
      cbc_pkg::rsp_type circ;
      if (pts_in_contour == 2'd0) begin
         box_min_x = pt.point_x;
         box_max_x = pt.point_x;
         box_min_y = pt.point_y;
         box_max_y = pt.point_y;
      end else begin
         // min and max are tracked independently
         if (pt.point_x < box_min_x) box_min_x = pt.point_x;
         if (pt.point_x > box_max_x) box_max_x = pt.point_x;
         if (pt.point_y < box_min_y) box_min_y = pt.point_y;
         if (pt.point_y > box_max_y) box_max_y = pt.point_y;
      end
      if (pts_in_contour != 2'd3) pts_in_contour = pts_in_contour + 2'd1;
      if (pt.last_point) begin
         contours_sent++;
         if (pts_in_contour >= 2'd2) begin
            sum_x = int'(box_min_x) + int'(box_max_x);
            sum_y = int'(box_min_y) + int'(box_max_y);
            dx = int'(box_max_x) - int'(box_min_x);
            dy = int'(box_max_y) - int'(box_min_y);
            circ.center_x = sum_x[cbc_pkg::COORD_W:1];
            circ.center_y = sum_y[cbc_pkg::COORD_W:1];
            circ.diameter = floor_root(dx * dx + dy * dy);
            circle_q = {circle_q, circ};
         end
         pts_in_contour = 2'd0;
      end
   endtask

   // valid stays high between back-to-back items, only lowered for a gap
   task automatic send_point(input logic [cbc_pkg::COORD_W-1:0] x,
                             input logic [cbc_pkg::COORD_W-1:0] y,
                             input logic last);
      cbc_pkg::req_type pt;
      pt.point_x = x;
      pt.point_y = y;
      pt.last_point = last;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= pt;
      do @(posedge clock); while (!req_ready);
      points_sent++;
      track_point(pt);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (holding) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      forever begin
         @(hold_trigger);
         holding <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (circle_q.size() == 0) begin
            errors++;
            $display("%0t: circle item with none expected: cx=%0d cy=%0d d=%0d", $time,
                     rsp_data.center_x, rsp_data.center_y, rsp_data.diameter);
         end else begin
            circle_want = circle_q.pop_front();
            circles_checked <= circles_checked + 1;
            if (rsp_data.center_x !== circle_want.center_x) begin
               errors++;
               $display("%0t: center_x expected %0d actual %0d", $time,
                        circle_want.center_x, rsp_data.center_x);
            end
            if (rsp_data.center_y !== circle_want.center_y) begin
               errors++;
               $display("%0t: center_y expected %0d actual %0d", $time,
                        circle_want.center_y, rsp_data.center_y);
            end
            if (rsp_data.diameter !== circle_want.diameter) begin
               errors++;
               $display("%0t: diameter expected %0d actual %0d", $time,
                        circle_want.diameter, rsp_data.diameter);
            end
         end
      end
   end

   function automatic logic [cbc_pkg::COORD_W-1:0] pick_coord(input int mode, input int base);
      int v;
      case (mode)
         0: v = $urandom_range(COORD_TOP);
         1: begin
            case ($urandom_range(2))
               0: v = 0;
               1: v = COORD_TOP;
               default: v = $urandom_range(COORD_TOP);
            endcase
         end
         default: begin
            v = base + $urandom_range(15) - 8;
            if (v < 0) v = 0;
            if (v > COORD_TOP) v = COORD_TOP;
         end
      endcase
      return v[cbc_pkg::COORD_W-1:0];
   endfunction

   task automatic random_contour();
      int len, mode, base_x, base_y, r;
      logic [cbc_pkg::COORD_W-1:0] px, py;
      r = $urandom_range(99);
      if (r < 15) len = 1;
      else if (r < 35) len = 2;
      else if (r < 50) len = 3;
      else len = $urandom_range(16, 4);
      mode = $urandom_range(3);
      base_x = $urandom_range(COORD_TOP);
      base_y = $urandom_range(COORD_TOP);
      px = pick_coord(mode, base_x);
      py = pick_coord(mode, base_y);
      for (int i = 0; i < len; i++) begin
         // mode 3 repeats one point for the whole contour
         if (mode != 3 && i != 0) begin
            px = pick_coord(mode, base_x);
            py = pick_coord(mode, base_y);
         end
         send_point(px, py, i == len - 1);
      end
   endtask

   task automatic run_contours(input int n_points);
      int start;
      start = points_sent;
      while (points_sent - start < n_points) random_contour();
   endtask

   task automatic wait_drained();
      while (circle_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      // single point contours give nothing
      send_point(12'd0, 12'd0, 1'b1);
      send_point(12'hFFF, 12'hFFF, 1'b1);
      // full diagonal, both orientations
      send_point(12'd0, 12'd0, 1'b0);
      send_point(12'hFFF, 12'hFFF, 1'b1);
      send_point(12'hFFF, 12'd0, 1'b0);
      send_point(12'd0, 12'hFFF, 1'b1);
      // identical points
      send_point(12'hFFF, 12'd0, 1'b0);
      send_point(12'hFFF, 12'd0, 1'b0);
      send_point(12'hFFF, 12'd0, 1'b1);
      // one point moving min x and max y at once
      send_point(12'd100, 12'd100, 1'b0);
      send_point(12'd50, 12'd200, 1'b0);
      send_point(12'd150, 12'd20, 1'b0);
      send_point(12'd80, 12'd80, 1'b1);
      // count saturates on a longer contour
      send_point(12'd2048, 12'd1, 1'b0);
      send_point(12'd2047, 12'd4094, 1'b0);
      send_point(12'd1, 12'd2048, 1'b0);
      send_point(12'd4094, 12'd2047, 1'b0);
      send_point(12'd7, 12'd9, 1'b1);
      // single point right after a result
      send_point(12'hAAA, 12'h555, 1'b1);
      send_point(12'h555, 12'hAAA, 1'b0);
      send_point(12'hAAA, 12'h555, 1'b1);
   endtask

   task automatic test_no_idling();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_contours(440);
   endtask

   task automatic test_sender_idle();
      send_idle_pct = 66;
      recv_stall_pct = 0;
      run_contours(440);
   endtask

   task automatic test_receiver_stall();
      send_idle_pct = 0;
      recv_stall_pct = 66;
      run_contours(440);
   endtask

   task automatic test_both_idle();
      send_idle_pct = 31;
      recv_stall_pct = 31;
      run_contours(440);
   endtask

   task automatic test_input_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      -> hold_trigger;
      // short contours keep the root unit and output busy while results back up
      for (int i = 0; i < 60; i++) begin
         send_point(12'($urandom_range(COORD_TOP)), 12'($urandom_range(COORD_TOP)), 1'b0);
         send_point(12'($urandom_range(COORD_TOP)), 12'($urandom_range(COORD_TOP)), 1'b1);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_no_idling();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_input_backpressure();
      req_valid <= 1'b0;
      wait_drained();
      $display("sent %0d points in %0d contours, %0d circles checked", points_sent,
               contours_sent, circles_checked);
      $display("covered extremes, single and identical points, gaps, stalls and a long hold");
      if (errors == 0 && circle_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0t: %0d mismatches, %0d circles still expected", $time, errors,
                  circle_q.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
